### src/mst_pkg.sv
// Shared types and constants of the multi-slot countdown timer.
// No dependencies; every other file but mst_slot_mem refers to it by scoped names.
package mst_pkg;

  localparam int CMD_W  = 2;
  localparam int SECS_W = 16;
  localparam int REM_W  = 17;
  localparam int KIND_W = 2;
  localparam int SLOT_W = 6;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNLOAD = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADD_ACK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK_END = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNLOADED = 2'd3;

  typedef logic [REM_W-1:0] rem_t;

  // Outcome of one pass of a slot count through the shared step unit.
  typedef struct packed {
    logic expire;
    rem_t dec;
  } step_res_t;

endpackage

### src/mst_req_if.sv
// Command channel of the countdown timer: valid/ready plus command payload.
// Depends on mst_pkg.
interface mst_req_if;
  logic                         valid;
  logic                         ready;
  logic [mst_pkg::CMD_W-1:0]    cmd;
  logic [mst_pkg::SECS_W-1:0]   seconds;

  modport source (output valid, cmd, seconds, input ready);
  modport sink   (input valid, cmd, seconds, output ready);
endinterface

### src/mst_rsp_if.sv
// Result channel of the countdown timer: valid/ready plus result payload.
// Depends on mst_pkg.
interface mst_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mst_pkg::KIND_W-1:0]   kind;
  logic                         no_space;
  logic [mst_pkg::SLOT_W-1:0]   slot;
  logic                         any_running;
  logic                         last;

  modport source (output valid, kind, no_space, slot, any_running, last, input ready);
  modport sink   (input valid, kind, no_space, slot, any_running, last, output ready);
endinterface

### src/mst_slot_mem.sv
// Remaining-count store: one write port, one read port, registered read.
// No dependencies beyond its parameters.
module mst_slot_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 17
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/mst_step_unit.sv
// Shared decrement-and-compare unit used once per slot during a tick.
// Depends on mst_pkg.
module mst_step_unit (
  input  mst_pkg::rem_t      remaining,
  output mst_pkg::step_res_t res
);

  // A count of one or zero runs out on this tick.
  assign res.expire = (remaining <= mst_pkg::rem_t'(1));
  assign res.dec    = remaining - mst_pkg::rem_t'(1);

endmodule

### src/multi_slot_countdown_timer.sv
// Multi-slot countdown timer: sequencer walking the slot table one slot at a time.
// Add: scan for the lowest free slot, one result.
// Tick: read, then step through the shared unit, per slot.
// Unload: one result. One command in flight; stalls only while the result register is full.
// Synchronous reset frees all slots; stored counts are not cleared (only read when running).
module multi_slot_countdown_timer #(
  parameter int NUM_SLOTS = 16
) (
  input logic       clk,
  input logic       rst,
  mst_req_if.sink   req,
  mst_rsp_if.source rsp
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SW = mst_pkg::SLOT_W;
  localparam int RW = mst_pkg::REM_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_TRD  = 3'd2;
  localparam logic [2:0] S_TEV  = 3'd3;
  localparam logic [2:0] S_TEND = 3'd4;
  localparam logic [2:0] S_UNLD = 3'd5;

  logic [2:0]                        state, state_next;
  logic [IW-1:0]                     idx, idx_next;
  logic [mst_pkg::SECS_W-1:0]        seconds, seconds_next;
  logic [NUM_SLOTS-1:0]              used, used_next;
  logic [NUM_SLOTS-1:0]              running, running_next;
  logic                              any_run, any_run_next;

  logic                              out_valid;
  logic [mst_pkg::KIND_W-1:0]        out_kind;
  logic                              out_no_space;
  logic [SW-1:0]                     out_slot;
  logic                              out_any;
  logic                              out_last;

  logic                              out_free;
  logic                              emit;
  logic [mst_pkg::KIND_W-1:0]        e_kind;
  logic                              e_no_space;
  logic [SW-1:0]                     e_slot;
  logic                              e_any;

  logic                              mem_we;
  mst_pkg::rem_t                     mem_wdata;
  mst_pkg::rem_t                     mem_rdata;
  mst_pkg::step_res_t                step;

  mst_slot_mem #(
    .DEPTH (NUM_SLOTS),
    .AW    (IW),
    .DW    (RW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx),
    .wdata (mem_wdata),
    .raddr (idx),
    .rdata (mem_rdata)
  );

  mst_step_unit u_step (
    .remaining (mem_rdata),
    .res       (step)
  );

  assign req.ready = (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid       = out_valid;
  assign rsp.kind        = out_kind;
  assign rsp.no_space    = out_no_space;
  assign rsp.slot        = out_slot;
  assign rsp.any_running = out_any;
  assign rsp.last        = out_last;

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    seconds_next = seconds;
    used_next    = used;
    running_next = running;
    any_run_next = any_run;
    emit         = 1'b0;
    e_kind       = mst_pkg::KIND_ADD_ACK;
    e_no_space   = 1'b0;
    e_slot       = '0;
    e_any        = 1'b0;
    mem_we       = 1'b0;
    mem_wdata    = RW'(seconds);

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          idx_next = '0;
          case (req.cmd)
            mst_pkg::CMD_ADD: begin
              seconds_next = req.seconds;
              state_next   = S_ADD;
            end
            mst_pkg::CMD_TICK: begin
              any_run_next = 1'b0;
              state_next   = S_TRD;
            end
            mst_pkg::CMD_UNLOAD: state_next = S_UNLD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (!used[idx]) begin
          if (out_free) begin
            emit              = 1'b1;
            e_slot            = SW'(idx);
            mem_we            = 1'b1;
            used_next[idx]    = 1'b1;
            running_next[idx] = 1'b1;
            state_next        = S_IDLE;
          end
        end else if (idx == LAST_IDX) begin
          if (out_free) begin
            emit       = 1'b1;
            e_no_space = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      S_TRD: state_next = S_TEV;
      S_TEV: begin
        logic adv;
        adv = 1'b1;
        if (used[idx] && running[idx]) begin
          if (step.expire) begin
            if (out_free) begin
              emit              = 1'b1;
              e_kind            = mst_pkg::KIND_EXPIRED;
              e_slot            = SW'(idx);
              running_next[idx] = 1'b0;
            end else begin
              adv = 1'b0;
            end
          end else begin
            mem_we       = 1'b1;
            mem_wdata    = step.dec;
            any_run_next = 1'b1;
          end
        end
        if (adv) begin
          if (idx == LAST_IDX) begin
            state_next = S_TEND;
          end else begin
            idx_next   = idx + IW'(1);
            state_next = S_TRD;
          end
        end
      end
      S_TEND: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = mst_pkg::KIND_TICK_END;
          e_any      = any_run;
          state_next = S_IDLE;
        end
      end
      S_UNLD: begin
        if (out_free) begin
          emit         = 1'b1;
          e_kind       = mst_pkg::KIND_UNLOADED;
          used_next    = '0;
          running_next = '0;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      running   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      used    <= used_next;
      running <= running_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    idx     <= idx_next;
    seconds <= seconds_next;
    any_run <= any_run_next;
    if (emit) begin
      out_kind     <= e_kind;
      out_no_space <= e_no_space;
      out_slot     <= e_slot;
      out_any      <= e_any;
      // only expiries are followed by more results of the same command
      out_last     <= (e_kind != mst_pkg::KIND_EXPIRED);
    end
  end

endmodule
